>>> hw/rtl/bpc_pkg.sv
// Shared types and constants for the barometric compensation block.
// Used by the divider, the top level and the testbench.
// No dependencies.
package bpc_pkg;

  // Configuration port geometry: four registers on an 8-byte stride.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 64;

  // Pipeline depths.
  localparam int FRONT_STAGES = 12;
  localparam int DIV_STEPS    = 64;
  localparam int BACK_STAGES  = 6;

  // Arithmetic constants of the compensation formulas.
  localparam logic signed [32:0] TEMP_OFFSET = 33'sd128000;
  localparam logic [20:0]        PRESS_BASE  = 21'd1048576;
  localparam logic [11:0]        DIV_SCALE   = 12'd3125;
  localparam logic signed [31:0] CENTI_ROUND = 32'sd128;
  localparam logic [63:0]        BASE_BIAS   = 64'h0000_8000_0000_0000;

  // Register indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_TEMP  = 2'd0,
    REG_PLOW  = 2'd1,
    REG_PHIGH = 2'd2,
    REG_P9    = 2'd3
  } reg_idx_t;

  // Fields that ride alongside the divider.
  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic               zero;
    logic               neg;
  } div_side_t;

  typedef struct packed {
    logic [63:0] num;
    logic [30:0] den;
    div_side_t   side;
  } div_req_t;

  typedef struct packed {
    logic [63:0] quot;
    div_side_t   side;
  } div_rsp_t;

  // One finished result word.
  typedef struct packed {
    logic signed [31:0] centi;
    logic signed [31:0] fine;
    logic [31:0]        press;
    logic               zero;
  } res_t;

endpackage

>>> hw/rtl/bpc_ifs.sv
// Valid/ready channel interfaces for raw samples and compensated results.
// No dependencies.
interface bpc_sample_if;
  logic        valid;
  logic        ready;
  logic [19:0] raw_temperature;
  logic [19:0] raw_pressure;
  modport source (output valid, raw_temperature, raw_pressure, input ready);
  modport sink (input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface bpc_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature_centi;
  logic signed [31:0] fine_temperature;
  logic [31:0]        pressure_q24_8;
  logic               divisor_zero;
  modport source (output valid, temperature_centi, fine_temperature, pressure_q24_8,
                  divisor_zero, input ready);
  modport sink (input valid, temperature_centi, fine_temperature, pressure_q24_8,
                divisor_zero, output ready);
endinterface

>>> hw/rtl/bpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on bpc_pkg for the step count and the request/response structs.
module bpc_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              in_valid,
  input  bpc_pkg::div_req_t req,
  output logic              out_valid,
  output bpc_pkg::div_rsp_t rsp
);
  import bpc_pkg::*;

  logic [63:0]          st_num  [DIV_STEPS];
  logic [30:0]          st_rem  [DIV_STEPS];
  logic [30:0]          st_den  [DIV_STEPS];
  div_side_t            st_side [DIV_STEPS];
  logic [DIV_STEPS-1:0] st_v;

  // Valid bits move with the data and hold on a stall.
  always_ff @(posedge clk) begin
    if (rst) begin
      st_v <= '0;
    end else if (adv) begin
      st_v <= {st_v[DIV_STEPS-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [30:0] rem_in;
    logic [30:0] den_in;
    logic [63:0] num_in;
    div_side_t   side_in;
    logic [31:0] trial;
    logic [31:0] diff;
    logic        take;

    if (k == 0) begin : g_first
      assign rem_in  = '0;
      assign den_in  = req.den;
      assign num_in  = req.num;
      assign side_in = req.side;
    end else begin : g_next
      assign rem_in  = st_rem[k-1];
      assign den_in  = st_den[k-1];
      assign num_in  = st_num[k-1];
      assign side_in = st_side[k-1];
    end

    // Shift in the next dividend bit and subtract when the divisor fits.
    assign trial = {rem_in, num_in[63]};
    assign diff  = trial - {1'b0, den_in};
    assign take  = (trial >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (adv) begin
        st_rem[k]  <= take ? diff[30:0] : trial[30:0];
        st_num[k]  <= {num_in[62:0], take};
        st_den[k]  <= den_in;
        st_side[k] <= side_in;
      end
    end
  end

  assign out_valid = st_v[DIV_STEPS-1];
  assign rsp.quot  = st_num[DIV_STEPS-1];
  assign rsp.side  = st_side[DIV_STEPS-1];

endmodule

>>> hw/rtl/baro_temp_pressure_compensation.sv
// Top level of the barometric temperature and pressure compensation block.
// Depends on bpc_pkg, the channel interfaces in bpc_ifs and the divider bpc_div.
//
// Usage: a raw temperature and raw pressure pair enters on the sample channel
// and one result word leaves on the result channel for every pair: temperature
// in hundredths of a degree, fine temperature, Q24.8 pressure and a flag that
// marks a zero pressure divisor (pressure then reads 0).
// Calibration is written over the APB port (8-byte stride); the user writes it
// only while no word is in flight, which the block itself does not enforce.
// Reads return the stored register values. The path runs through 12 front
// stages for temperature and the divisor, 64 divider stages that settle one
// quotient bit each, and 6 back stages for the pressure polish, then the
// output buffer. The block takes one word per cycle while the output buffer
// has room; the divider chain sets the depth. The output buffer holds two words.
// While the receiver stalls, the pipeline keeps moving until the buffer is full,
// then everything holds in place and sample.ready drops. Reset clears all valid
// bits, the buffer and every calibration register.
module baro_temp_pressure_compensation (
  input  logic                          clk,
  input  logic                          rst,
  bpc_sample_if.sink                    sample,
  bpc_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bpc_pkg::ADDR_W-1:0]    paddr,
  input  logic [bpc_pkg::DATA_W-1:0]    pwdata,
  output logic [bpc_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import bpc_pkg::*;

  // Calibration registers.
  logic [47:0] temp_calib;
  logic [63:0] press_calib_low;
  logic [63:0] press_calib_high;
  logic [15:0] press_calib_p9;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[4:3]);
  assign cfg_wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_calib       <= '0;
      press_calib_low  <= '0;
      press_calib_high <= '0;
      press_calib_p9   <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_TEMP:  temp_calib       <= pwdata[47:0];
        REG_PLOW:  press_calib_low  <= pwdata;
        REG_PHIGH: press_calib_high <= pwdata;
        REG_P9:    press_calib_p9   <= pwdata[15:0];
        default:   ;
      endcase
    end
  end

  // Register read back.
  always_comb begin
    case (reg_idx)
      REG_TEMP:  prdata = {16'd0, temp_calib};
      REG_PLOW:  prdata = press_calib_low;
      REG_PHIGH: prdata = press_calib_high;
      REG_P9:    prdata = {48'd0, press_calib_p9};
      default:   prdata = '0;
    endcase
  end

  // Coefficient slices.
  logic [15:0]        t1, p1;
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

  assign t1 = temp_calib[15:0];
  assign t2 = temp_calib[31:16];
  assign t3 = temp_calib[47:32];
  assign p1 = press_calib_low[15:0];
  assign p2 = press_calib_low[31:16];
  assign p3 = press_calib_low[47:32];
  assign p4 = press_calib_low[63:48];
  assign p5 = press_calib_high[15:0];
  assign p6 = press_calib_high[31:16];
  assign p7 = press_calib_high[47:32];
  assign p8 = press_calib_high[63:48];
  assign p9 = press_calib_p9;

  // Global advance: the whole pipeline moves while the output buffer has room.
  logic [1:0] cnt;
  logic       adv;

  assign adv          = (cnt != 2'd2);
  assign sample.ready = adv;

  logic [FRONT_STAGES-1:0] fv;
  logic [BACK_STAGES-1:0]  bv;
  logic                    div_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
      bv <= '0;
    end else if (adv) begin
      fv <= {fv[FRONT_STAGES-2:0], sample.valid};
      bv <= {bv[BACK_STAGES-2:0], div_valid};
    end
  end

  // Stage 1: offsets of the raw samples.
  logic signed [17:0] s1_a;
  logic signed [16:0] s1_d;
  logic [20:0]        s1_padc;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a    <= $signed({1'b0, sample.raw_temperature[19:3]}) - $signed({1'b0, t1, 1'b0});
      s1_d    <= $signed({1'b0, sample.raw_temperature[19:4]}) - $signed({1'b0, t1});
      s1_padc <= PRESS_BASE - {1'b0, sample.raw_pressure};
    end
  end

  // Stage 2: first temperature products.
  logic signed [33:0] a_t2, d_sq;
  logic signed [31:0] s2_at, s2_dd;
  logic [20:0]        s2_padc;

  assign a_t2 = s1_a * t2;
  assign d_sq = s1_d * s1_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_at   <= a_t2[31:0];
      s2_dd   <= d_sq[31:0];
      s2_padc <= s1_padc;
    end
  end

  // Stage 3: scale and apply T3.
  logic signed [31:0] sq_sh, at_sh;
  logic signed [47:0] sq_t3;
  logic signed [31:0] s3_v1, s3_st;
  logic [20:0]        s3_padc;

  assign sq_sh = s2_dd >>> 12;
  assign at_sh = s2_at >>> 11;
  assign sq_t3 = sq_sh * t3;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_v1   <= at_sh;
      s3_st   <= sq_t3[31:0];
      s3_padc <= s2_padc;
    end
  end

  // Stage 4: fine temperature.
  logic signed [31:0] st_sh;
  logic signed [31:0] s4_fine;
  logic [20:0]        s4_padc;

  assign st_sh = s3_st >>> 14;

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_fine <= s3_v1 + st_sh;
      s4_padc <= s3_padc;
    end
  end

  // Stage 5: centi-degrees and the pressure offset term.
  logic signed [31:0] centi_sum, centi_sh;
  logic signed [32:0] s5_s;
  logic signed [31:0] s5_fine, s5_centi;
  logic [20:0]        s5_padc;

  assign centi_sum = (s4_fine <<< 2) + s4_fine + CENTI_ROUND;
  assign centi_sh  = centi_sum >>> 8;

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_s     <= $signed({s4_fine[31], s4_fine}) - TEMP_OFFSET;
      s5_fine  <= s4_fine;
      s5_centi <= centi_sh;
      s5_padc  <= s4_padc;
    end
  end

  // Stage 6: square of the offset and the linear products.
  logic signed [65:0] s_sq;
  logic signed [48:0] s_p5, s_p2;
  logic [63:0]        s6_sq;
  logic signed [48:0] s6_sp5, s6_sp2;
  logic signed [31:0] s6_fine, s6_centi;
  logic [20:0]        s6_padc;

  assign s_sq = s5_s * s5_s;
  assign s_p5 = s5_s * p5;
  assign s_p2 = s5_s * p2;

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_sq    <= s_sq[63:0];
      s6_sp5   <= s_p5;
      s6_sp2   <= s_p2;
      s6_fine  <= s5_fine;
      s6_centi <= s5_centi;
      s6_padc  <= s5_padc;
    end
  end

  // Stage 7: square times P6 and P3, as low and high partial products.
  logic signed [48:0] m6lo, m3lo;
  logic signed [47:0] m6hi, m3hi;
  logic signed [48:0] s7_m6lo, s7_m3lo, s7_sp5, s7_sp2;
  logic [31:0]        s7_m6hi, s7_m3hi;
  logic signed [31:0] s7_fine, s7_centi;
  logic [20:0]        s7_padc;

  assign m6lo = $signed({1'b0, s6_sq[31:0]}) * p6;
  assign m6hi = $signed(s6_sq[63:32]) * p6;
  assign m3lo = $signed({1'b0, s6_sq[31:0]}) * p3;
  assign m3hi = $signed(s6_sq[63:32]) * p3;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_m6lo  <= m6lo;
      s7_m6hi  <= m6hi[31:0];
      s7_m3lo  <= m3lo;
      s7_m3hi  <= m3hi[31:0];
      s7_sp5   <= s6_sp5;
      s7_sp2   <= s6_sp2;
      s7_fine  <= s6_fine;
      s7_centi <= s6_centi;
      s7_padc  <= s6_padc;
    end
  end

  // Stage 8: second-order pressure term and the cubic partial sum.
  logic [63:0]        s8_w2, s8_x3;
  logic signed [48:0] s8_sp2;
  logic signed [31:0] s8_fine, s8_centi;
  logic [20:0]        s8_padc;

  always_ff @(posedge clk) begin
    if (adv) begin
      s8_w2    <= 64'(s7_m6lo) + {s7_m6hi, 32'd0} + (64'(s7_sp5) <<< 17)
                  + (64'(p4) <<< 35);
      s8_x3    <= 64'(s7_m3lo) + {s7_m3hi, 32'd0};
      s8_sp2   <= s7_sp2;
      s8_fine  <= s7_fine;
      s8_centi <= s7_centi;
      s8_padc  <= s7_padc;
    end
  end

  // Stage 9: divisor base and dividend before scaling.
  logic signed [63:0] x3_sh;
  logic [63:0]        s9_base, s9_nd;
  logic signed [31:0] s9_fine, s9_centi;

  assign x3_sh = $signed(s8_x3) >>> 8;

  always_ff @(posedge clk) begin
    if (adv) begin
      s9_base  <= x3_sh + (64'(s8_sp2) <<< 12) + BASE_BIAS;
      s9_nd    <= {12'd0, s8_padc, 31'd0} - s8_w2;
      s9_fine  <= s8_fine;
      s9_centi <= s8_centi;
    end
  end

  // Stage 10: partial products by P1 and by the scale constant.
  logic [47:0]        pm_lo_p, pm_hi_p;
  logic [43:0]        n_lo_p, n_hi_p;
  logic [47:0]        s10_pm_lo;
  logic [31:0]        s10_pm_hi, s10_n_hi;
  logic [43:0]        s10_n_lo;
  logic signed [31:0] s10_fine, s10_centi;

  assign pm_lo_p = s9_base[31:0] * p1;
  assign pm_hi_p = s9_base[63:32] * p1;
  assign n_lo_p  = s9_nd[31:0] * DIV_SCALE;
  assign n_hi_p  = s9_nd[63:32] * DIV_SCALE;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10_pm_lo <= pm_lo_p;
      s10_pm_hi <= pm_hi_p[31:0];
      s10_n_lo  <= n_lo_p;
      s10_n_hi  <= n_hi_p[31:0];
      s10_fine  <= s9_fine;
      s10_centi <= s9_centi;
    end
  end

  // Stage 11: assemble divisor product and dividend.
  logic [63:0]        s11_pm, s11_num;
  logic signed [31:0] s11_fine, s11_centi;

  always_ff @(posedge clk) begin
    if (adv) begin
      s11_pm    <= {16'd0, s10_pm_lo} + {s10_pm_hi, 32'd0};
      s11_num   <= {20'd0, s10_n_lo} + {s10_n_hi, 32'd0};
      s11_fine  <= s10_fine;
      s11_centi <= s10_centi;
    end
  end

  // Stage 12: signs and magnitudes for the divider.
  logic signed [63:0] den_sh;
  logic [30:0]        den31;
  logic               num_neg, den_neg;
  div_req_t           s12_req;

  assign den_sh  = $signed(s11_pm) >>> 33;
  assign den31   = den_sh[30:0];
  assign num_neg = s11_num[63];
  assign den_neg = den31[30];

  always_ff @(posedge clk) begin
    if (adv) begin
      s12_req.num        <= num_neg ? (64'd0 - s11_num) : s11_num;
      s12_req.den        <= den_neg ? (31'd0 - den31) : den31;
      s12_req.side.centi <= s11_centi;
      s12_req.side.fine  <= s11_fine;
      s12_req.side.zero  <= (den31 == 31'd0);
      s12_req.side.neg   <= num_neg ^ den_neg;
    end
  end

  // Divider chain.
  div_rsp_t div_rsp;

  bpc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (fv[FRONT_STAGES-1]),
    .req       (s12_req),
    .out_valid (div_valid),
    .rsp       (div_rsp)
  );

  // Back 1: signed quotient.
  logic [63:0] b1_qs;
  div_side_t   b1_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      b1_qs   <= div_rsp.side.neg ? (64'd0 - div_rsp.quot) : div_rsp.quot;
      b1_side <= div_rsp.side;
    end
  end

  // Back 2: square of the scaled quotient and the P8 term, as partials.
  logic signed [63:0] h_sh;
  logic [63:0]        h_lo_sq, h_cross;
  logic signed [48:0] q8lo;
  logic signed [47:0] q8hi;
  logic [63:0]        b2_msq, b2_qs;
  logic [31:0]        b2_cross, b2_q8hi;
  logic signed [48:0] b2_q8lo;
  div_side_t          b2_side;

  assign h_sh    = $signed(b1_qs) >>> 13;
  assign h_lo_sq = h_sh[31:0] * h_sh[31:0];
  assign h_cross = h_sh[31:0] * h_sh[63:32];
  assign q8lo    = $signed({1'b0, b1_qs[31:0]}) * p8;
  assign q8hi    = $signed(b1_qs[63:32]) * p8;

  always_ff @(posedge clk) begin
    if (adv) begin
      b2_msq   <= h_lo_sq;
      b2_cross <= h_cross[31:0];
      b2_q8lo  <= q8lo;
      b2_q8hi  <= q8hi[31:0];
      b2_qs    <= b1_qs;
      b2_side  <= b1_side;
    end
  end

  // Back 3: assemble the square and the P8 product.
  logic [63:0] b3_hsq, b3_x2f, b3_qs;
  div_side_t   b3_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      b3_hsq  <= b2_msq + {b2_cross[30:0], 33'd0};
      b3_x2f  <= 64'(b2_q8lo) + {b2_q8hi, 32'd0};
      b3_qs   <= b2_qs;
      b3_side <= b2_side;
    end
  end

  // Back 4: square times P9 as partials; scale the P8 term.
  logic signed [48:0] r9lo;
  logic signed [47:0] r9hi;
  logic signed [63:0] x2_sh;
  logic signed [48:0] b4_r9lo;
  logic [31:0]        b4_r9hi;
  logic [63:0]        b4_x2, b4_qs;
  div_side_t          b4_side;

  assign r9lo  = $signed({1'b0, b3_hsq[31:0]}) * p9;
  assign r9hi  = $signed(b3_hsq[63:32]) * p9;
  assign x2_sh = $signed(b3_x2f) >>> 19;

  always_ff @(posedge clk) begin
    if (adv) begin
      b4_r9lo <= r9lo;
      b4_r9hi <= r9hi[31:0];
      b4_x2   <= x2_sh;
      b4_qs   <= b3_qs;
      b4_side <= b3_side;
    end
  end

  // Back 5: assemble the P9 product.
  logic [63:0] b5_x1f, b5_x2, b5_qs;
  div_side_t   b5_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      b5_x1f  <= 64'(b4_r9lo) + {b4_r9hi, 32'd0};
      b5_x2   <= b4_x2;
      b5_qs   <= b4_qs;
      b5_side <= b4_side;
    end
  end

  // Back 6: corrected pressure sum; only the bits that survive are kept.
  logic signed [63:0] x1_sh;
  logic [63:0]        corr_sum;
  logic [39:0]        b6_s;
  div_side_t          b6_side;

  assign x1_sh    = $signed(b5_x1f) >>> 25;
  assign corr_sum = b5_qs + x1_sh + b5_x2;

  always_ff @(posedge clk) begin
    if (adv) begin
      b6_s    <= corr_sum[39:0];
      b6_side <= b5_side;
    end
  end

  // Final word: add the P7 offset, force zero on a zero divisor.
  logic signed [31:0] p7_term;
  res_t               res_new;

  assign p7_term       = 32'(p7) <<< 4;
  assign res_new.centi = b6_side.centi;
  assign res_new.fine  = b6_side.fine;
  assign res_new.zero  = b6_side.zero;
  assign res_new.press = b6_side.zero ? 32'd0 : (b6_s[39:8] + p7_term);

  // Two-word output buffer.
  res_t slot0, slot1;
  logic push, pop;

  assign push = adv & bv[BACK_STAGES-1];
  assign pop  = result.valid & result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push && (cnt == 2'd0 || (cnt == 2'd1 && pop))) begin
      slot0 <= res_new;
    end else if (pop) begin
      slot0 <= slot1;
    end
    if (push && cnt == 2'd1 && !pop) begin
      slot1 <= res_new;
    end
  end

  assign result.valid             = (cnt != 2'd0);
  assign result.temperature_centi = slot0.centi;
  assign result.fine_temperature  = slot0.fine;
  assign result.pressure_q24_8    = slot0.press;
  assign result.divisor_zero      = slot0.zero;

`ifndef SYNTHESIS
  // A word flagged for a zero divisor always carries zero pressure.
  a_zero_press: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.divisor_zero) |-> (result.pressure_q24_8 == 32'd0))
    else $error("zero divisor word with nonzero pressure");

  // When the buffer is full, no stage valid bit may change.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> ($stable(fv) && $stable(bv)))
    else $error("pipeline moved while the output buffer was full");

  // A word pushed into the buffer is offered on the next cycle.
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    push |=> result.valid)
    else $error("pushed word not offered");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench for the barometric temperature and pressure compensation block.
// Depends on bpc_pkg, the channel interfaces in bpc_ifs and the top level RTL.
// Drives raw sample words and APB calibration writes and checks every result word.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int DRAIN_CYCLES = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  bpc_sample_if sample ();
  bpc_result_if result ();

  baro_temp_pressure_compensation dut (
    .clk(clk), .rst(rst), .sample(sample.sink), .result(result.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  // Shadow copy of the calibration registers.
  bit [47:0] cal_temp;
  bit [63:0] cal_plow;
  bit [63:0] cal_phigh;
  bit [15:0] cal_p9;

  res_t expected_words[$];
  int mismatches = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  function automatic bit [31:0] asr32(bit [31:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic bit [63:0] asr64(bit [63:0] x, int n);
    return $signed(x) >>> n;
  endfunction

  function automatic bit [63:0] sext64(bit [15:0] v);
    return {{48{v[15]}}, v};
  endfunction

  // Signed 64-bit division that truncates toward zero, wrapping on overflow.
  function automatic bit [63:0] div_trunc(bit [63:0] n, bit [63:0] d);
    bit [63:0] an;
    bit [63:0] ad;
    bit [63:0] q;
    an = n[63] ? 64'd0 - n : n;
    ad = d[63] ? 64'd0 - d : d;
    q = an / ad;
    return (n[63] != d[63]) ? 64'd0 - q : q;
  endfunction

  // Integer compensation of one raw sample pair under the current calibration.
  function automatic res_t compensate(bit [19:0] raw_t, bit [19:0] raw_p);
    res_t r;
    bit [31:0] adc_t, t1, t2, t3, a, v1, d, sq, v2, fine;
    bit [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
    bit [63:0] w1, w2, p, h, x1, x2;
    adc_t = {12'd0, raw_t};
    t1 = {16'd0, cal_temp[15:0]};
    t2 = {{16{cal_temp[31]}}, cal_temp[31:16]};
    t3 = {{16{cal_temp[47]}}, cal_temp[47:32]};
    p1 = {48'd0, cal_plow[15:0]};
    p2 = sext64(cal_plow[31:16]);
    p3 = sext64(cal_plow[47:32]);
    p4 = sext64(cal_plow[63:48]);
    p5 = sext64(cal_phigh[15:0]);
    p6 = sext64(cal_phigh[31:16]);
    p7 = sext64(cal_phigh[47:32]);
    p8 = sext64(cal_phigh[63:48]);
    p9 = sext64(cal_p9);
    // Temperature path, 32 bits wide.
    a = (adc_t >> 3) - (t1 << 1);
    v1 = asr32(a * t2, 11);
    d = (adc_t >> 4) - t1;
    sq = asr32(d * d, 12);
    v2 = asr32(sq * t3, 14);
    fine = v1 + v2;
    r.centi = asr32(fine * 32'd5 + 32'd128, 8);
    r.fine = fine;
    // Pressure path, 64 bits wide.
    w1 = {{32{fine[31]}}, fine} - 64'd128000;
    w2 = w1 * w1 * p6;
    w2 = w2 + ((w1 * p5) << 17);
    w2 = w2 + (p4 << 35);
    w1 = asr64(w1 * w1 * p3, 8) + ((w1 * p2) << 12);
    w1 = asr64(((64'd1 << 47) + w1) * p1, 33);
    if (w1 == 64'd0) begin
      r.press = '0;
      r.zero = 1'b1;
    end else begin
      p = 64'd1048576 - {44'd0, raw_p};
      p = div_trunc(((p << 31) - w2) * 64'd3125, w1);
      h = asr64(p, 13);
      x1 = asr64(p9 * h * h, 25);
      x2 = asr64(p8 * p, 19);
      p = asr64(p + x1 + x2, 8) + (p7 << 4);
      r.press = p[31:0];
      r.zero = 1'b0;
    end
    return r;
  endfunction

  task automatic report(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  // Receiver: ready toggles at random with the current stall rate.
  always @(negedge clk) begin
    result.ready <= rst ? 1'b0 : ($urandom_range(99) >= stall_pct);
  end

  // Result checker: compares each accepted word with the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (!rst && result.valid && result.ready) begin
      if (expected_words.size() == 0) begin
        report("result word with nothing expected");
      end else begin
        want = expected_words.pop_front();
        if (result.temperature_centi !== want.centi)
          report($sformatf("centi exp %0d got %0d", want.centi, result.temperature_centi));
        if (result.fine_temperature !== want.fine)
          report($sformatf("fine exp %0d got %0d", want.fine, result.fine_temperature));
        if (result.pressure_q24_8 !== want.press)
          report($sformatf("press exp %h got %h", want.press, result.pressure_q24_8));
        if (result.divisor_zero !== want.zero)
          report($sformatf("zero flag exp %b got %b", want.zero, result.divisor_zero));
      end
    end
  end

  // Sends one sample word; valid is left high so back-to-back words stay high.
  task automatic send_sample(bit [19:0] raw_t, bit [19:0] raw_p);
    while ($urandom_range(99) < idle_pct) begin
      sample.valid = 1'b0;
      @(negedge clk);
    end
    sample.valid = 1'b1;
    sample.raw_temperature = raw_t;
    sample.raw_pressure = raw_p;
    do @(posedge clk); while (!sample.ready);
    expected_words.push_back(compensate(raw_t, raw_p));
    @(negedge clk);
  endtask

  // Drops sample valid and lets all expected words arrive, then idles before it returns.
  task automatic drain();
    sample.valid = 1'b0;
    while (expected_words.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // APB write of one register followed by a read-back check.
  task automatic write_reg(reg_idx_t idx, bit [63:0] value);
    bit [63:0] want;
    case (idx)
      REG_TEMP: begin
        cal_temp = value[47:0];
        want = {16'd0, value[47:0]};
      end
      REG_PLOW: begin
        cal_plow = value;
        want = value;
      end
      REG_PHIGH: begin
        cal_phigh = value;
        want = value;
      end
      default: begin
        cal_p9 = value[15:0];
        want = {48'd0, value[15:0]};
      end
    endcase
    paddr = ADDR_W'(idx) << 3;
    pwdata = value;
    pwrite = 1'b1;
    psel = 1'b1;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    pwrite = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (prdata[15:0] !== want[15:0] || (idx != REG_P9 && prdata[47:16] !== want[47:16])
        || ((idx == REG_PLOW || idx == REG_PHIGH) && prdata[63:48] !== want[63:48]))
      report($sformatf("register %0d read %h exp %h", idx, prdata, want));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  task automatic load_calib(bit [47:0] t, bit [63:0] lo, bit [63:0] hi, bit [15:0] p9);
    write_reg(REG_TEMP, {16'd0, t});
    write_reg(REG_PLOW, lo);
    write_reg(REG_PHIGH, hi);
    write_reg(REG_P9, {48'd0, p9});
  endtask

  task automatic load_typical();
    load_calib({16'hFC18, 16'd26435, 16'd27504},
               {16'd2855, 16'd3024, 16'hD643, 16'd36477},
               {16'hC6F8, 16'd15500, 16'hFFF9, 16'd140}, 16'd6000);
  endtask

  // With all calibration at reset the pressure divisor is zero.
  task automatic test_reset_calibration();
    send_sample(20'd519888, 20'd415148);
    send_sample(20'hFFFFF, 20'h00000);
    drain();
  endtask

  // Typical calibration with raw field extremes and alternating bit patterns.
  task automatic test_field_extremes();
    load_typical();
    send_sample(20'd519888, 20'd415148);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'hAAAAA, 20'h55555);
    send_sample(20'h55555, 20'hAAAAA);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h80000, 20'h80000);
    drain();
  endtask

  // Zero P1 forces the divisor to zero; temperature stays valid.
  task automatic test_zero_divisor();
    write_reg(REG_PLOW, {16'd2855, 16'd3024, 16'hD643, 16'd0});
    send_sample(20'd519888, 20'd415148);
    send_sample(20'hFFFFF, 20'hFFFFF);
    drain();
  endtask

  // Calibration at its extremes: all ones, most negative slices and most positive slices.
  task automatic test_calibration_extremes();
    load_calib('1, '1, '1, 16'hFFFF);
    send_sample(20'hFFFFF, 20'h00000);
    send_sample(20'h00000, 20'hFFFFF);
    send_sample(20'h12345, 20'h6789A);
    drain();
    load_calib({16'h8000, 16'h8000, 16'hFFFF}, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF},
               {4{16'h8000}}, 16'h8000);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'h00000);
    send_sample(20'h7FFFF, 20'h40000);
    drain();
    load_calib({16'h7FFF, 16'h7FFF, 16'h0001}, {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001},
               {4{16'h7FFF}}, 16'h7FFF);
    send_sample(20'hFFFFF, 20'hFFFFF);
    send_sample(20'h00000, 20'h00000);
    drain();
  endtask

  // Random words across idle and receiver stall phases; calibration changes between phases.
  task automatic test_random();
    int idle_tab[4] = '{0, 48, 0, 9};
    int stall_tab[4] = '{0, 0, 48, 9};
    for (int ph = 0; ph < 8; ph++) begin
      idle_pct = idle_tab[ph % 4];
      stall_pct = stall_tab[ph % 4];
      if (ph % 2 == 0) begin
        load_typical();
        write_reg(REG_TEMP, {16'd0, 16'hFC18 + 16'($urandom_range(400)),
                  16'd26000 + 16'($urandom_range(900)), 16'd27000 + 16'($urandom_range(900))});
      end else begin
        load_calib({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                   16'($urandom));
      end
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(3) == 0)
          send_sample(20'($urandom), 20'($urandom));
        else
          send_sample(20'd480000 + 20'($urandom_range(80000)),
                      20'd250000 + 20'($urandom_range(250000)));
      end
      drain();
    end
  endtask

  initial begin
    sample.valid = 1'b0;
    sample.raw_temperature = '0;
    sample.raw_pressure = '0;
    result.ready = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_calibration();
    test_field_extremes();
    test_zero_divisor();
    test_calibration_extremes();
    test_random();
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
